/* hw/rtl/bntp_pkg.sv */
// Shared constants, request codes and control structs for the bigram predictor.
// Depends on nothing; every other file imports it.
package bntp_pkg;

    // History depth and symbol width
    localparam int HIST_DEPTH = 64;
    localparam int TOKEN_BITS = 8;
    localparam int TOKEN_SPAN = 1 << TOKEN_BITS;

    // Derived widths
    localparam int PTR_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(HIST_DEPTH + 1);

    // Fixed field widths of the channels
    localparam int REQ_TYPE_W = 2;
    localparam int TOKEN_W    = 8;
    localparam int BACK_W     = 7;
    localparam int LIVE_W     = 7;
    localparam int CMP_W      = (CNT_W > BACK_W) ? CNT_W : BACK_W;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_ADD     = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR   = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_PREDICT = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 2'd3;

    // Ring memory port controls
    typedef struct packed {
        logic                  wr;
        logic [PTR_W-1:0]      wr_addr;
        logic [TOKEN_BITS-1:0] wr_data;
        logic                  rd;
        logic [PTR_W-1:0]      rd_addr;
    } ring_ctl_t;

    // Tally unit controls
    typedef struct packed {
        logic                  restart;
        logic                  clr;
        logic                  look;
        logic                  upd;
        logic [TOKEN_BITS-1:0] addr;
        logic [CNT_W-1:0]      rec;
    } tally_ctl_t;

    // Tally unit status
    typedef struct packed {
        logic                  any;
        logic [TOKEN_BITS-1:0] best;
    } tally_stat_t;

    // One tally entry: hit count and recency of the newest hit
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] rec;
    } tally_entry_t;

endpackage

/* hw/rtl/bntp_req_if.sv */
// Request channel: valid/ready handshake with request type, token and back index.
// Depends on bntp_pkg for field widths.
interface bntp_req_if;
    import bntp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [TOKEN_W-1:0]    token;
    logic [BACK_W-1:0]     back_index;

    modport source (output valid, output req_type, output token, output back_index,
                    input ready);
    modport sink   (input valid, input req_type, input token, input back_index,
                    output ready);
endinterface

/* hw/rtl/bntp_rsp_if.sv */
// Response channel: valid/ready handshake with found flag, token and live count.
// Depends on bntp_pkg for field widths.
interface bntp_rsp_if;
    import bntp_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [TOKEN_W-1:0] token_out;
    logic [LIVE_W-1:0]  live_count;

    modport source (output valid, output found, output token_out, output live_count,
                    input ready);
    modport sink   (input valid, input found, input token_out, input live_count,
                    output ready);
endinterface

/* hw/rtl/bigram_next_token_predictor_top.sv */
// Bigram next-token predictor top level: request sequencer and response register.
// Predict runs a tally clear sweep, then up to two passes over the history entries
// through the shared tally update unit; one request at a time.
// Reset clears pointer, entry count, sequencer and response valid; memories are not reset.
// Depends on bntp_pkg, bntp_req_if, bntp_rsp_if, bntp_ring and bntp_tally.
module bigram_next_token_predictor_top (
    input  logic       clk,
    input  logic       rst_n,
    bntp_req_if.sink   cmd,
    bntp_rsp_if.source res
);
    import bntp_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_READ_WAIT = 4'd1;
    localparam logic [3:0] S_NEWEST    = 4'd2;
    localparam logic [3:0] S_CLEAR     = 4'd3;
    localparam logic [3:0] S_RING_RD   = 4'd4;
    localparam logic [3:0] S_RING_WAIT = 4'd5;
    localparam logic [3:0] S_TALLY     = 4'd6;
    localparam logic [3:0] S_STEP      = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    // Ring slot a given number back from the write pointer
    function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] wp,
                                                   input logic [CNT_W-1:0] off);
        logic [CNT_W:0] w;
        logic [CNT_W:0] o;
        logic [CNT_W:0] a;
        w = (CNT_W + 1)'(wp);
        o = (CNT_W + 1)'(off);
        if (w >= o)
        begin
            a = w - o;
        end
        else
        begin
            a = w + (CNT_W + 1)'(HIST_DEPTH) - o;
        end
        return a[PTR_W-1:0];
    endfunction

    logic [3:0]            state_reg, state_next;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [TOKEN_BITS-1:0] clr_reg, clr_next;
    logic                  pass_b_reg, pass_b_next;
    logic [TOKEN_BITS-1:0] newest_reg, newest_next;
    logic [TOKEN_BITS-1:0] follow_reg, follow_next;
    logic [TOKEN_BITS-1:0] hit_tok_reg, hit_tok_next;
    logic [CNT_W-1:0]      hit_rec_reg, hit_rec_next;
    logic                  pend_found_reg, pend_found_next;
    logic [TOKEN_BITS-1:0] pend_tok_reg, pend_tok_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [TOKEN_W-1:0]    out_tok_reg, out_tok_next;
    logic [LIVE_W-1:0]     out_live_reg, out_live_next;

    ring_ctl_t             rctl;
    tally_ctl_t            tctl;
    tally_stat_t           tstat;
    logic [TOKEN_BITS-1:0] ring_rd_data;
    logic                  accept;
    logic [TOKEN_BITS-1:0] in_tok;
    logic [CMP_W-1:0]      back_ext;
    logic [CMP_W-1:0]      count_ext;
    logic [CNT_W-1:0]      step_off;
    logic                  hit;
    logic [TOKEN_BITS-1:0] cand_tok;
    logic [CNT_W-1:0]      cand_rec;
    logic                  slot_free;

    bntp_ring u_ring (
        .clk     (clk),
        .ctl     (rctl),
        .rd_data (ring_rd_data)
    );

    bntp_tally u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tctl),
        .stat  (tstat)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign in_tok    = TOKEN_BITS'(cmd.token);
    assign back_ext  = CMP_W'(cmd.back_index);
    assign count_ext = CMP_W'(count_reg);
    assign step_off  = pass_b_reg ? idx_reg : (idx_reg + CNT_W'(1));
    assign slot_free = !out_valid_reg || res.ready;

    // Candidate hit for the current history step
    always_comb
    begin
        if (pass_b_reg)
        begin
            hit      = 1'b1;
            cand_tok = ring_rd_data;
            cand_rec = count_reg - idx_reg + CNT_W'(1);
        end
        else
        begin
            hit      = (ring_rd_data == newest_reg);
            cand_tok = follow_reg;
            cand_rec = count_reg - idx_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        pass_b_next     = pass_b_reg;
        newest_next     = newest_reg;
        follow_next     = follow_reg;
        hit_tok_next    = hit_tok_reg;
        hit_rec_next    = hit_rec_reg;
        pend_found_next = pend_found_reg;
        pend_tok_next   = pend_tok_reg;

        rctl            = '0;
        rctl.wr_addr    = wp_reg;
        rctl.wr_data    = in_tok;
        rctl.rd_addr    = ring_addr(wp_reg, step_off);
        tctl            = '0;
        tctl.addr       = hit_tok_reg;
        tctl.rec        = hit_rec_reg;

        case (state_reg)
            S_IDLE:
            begin
                pend_found_next = 1'b0;
                pend_tok_next   = '0;
                if (accept)
                begin
                    case (cmd.req_type)
                        REQ_ADD:
                        begin
                            rctl.wr    = 1'b1;
                            wp_next    = (wp_reg == PTR_W'(HIST_DEPTH - 1)) ? '0
                                                                          : wp_reg + PTR_W'(1);
                            if (count_reg != CNT_W'(HIST_DEPTH))
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_DONE;
                        end
                        REQ_CLEAR:
                        begin
                            wp_next    = '0;
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        REQ_PREDICT:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rctl.rd      = 1'b1;
                                rctl.rd_addr = ring_addr(wp_reg, CNT_W'(1));
                                state_next   = S_NEWEST;
                            end
                        end
                        REQ_READ:
                        begin
                            if ((back_ext != '0) && (back_ext <= count_ext))
                            begin
                                rctl.rd      = 1'b1;
                                rctl.rd_addr = ring_addr(wp_reg, CNT_W'(cmd.back_index));
                                state_next   = S_READ_WAIT;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ_WAIT:
            begin
                pend_found_next = 1'b1;
                pend_tok_next   = ring_rd_data;
                state_next      = S_DONE;
            end

            // Hold the newest token and start the tally sweep
            S_NEWEST:
            begin
                newest_next  = ring_rd_data;
                follow_next  = ring_rd_data;
                pass_b_next  = 1'b0;
                clr_next     = '0;
                tctl.restart = 1'b1;
                state_next   = S_CLEAR;
            end

            S_CLEAR:
            begin
                tctl.clr  = 1'b1;
                tctl.addr = clr_reg;
                clr_next  = clr_reg + TOKEN_BITS'(1);
                if (clr_reg == '1)
                begin
                    idx_next    = CNT_W'(1);
                    pass_b_next = (count_reg == CNT_W'(1));
                    state_next  = S_RING_RD;
                end
            end

            S_RING_RD:
            begin
                rctl.rd    = 1'b1;
                state_next = S_RING_WAIT;
            end

            // Decide on a hit and fetch its tally entry
            S_RING_WAIT:
            begin
                follow_next = ring_rd_data;
                if (hit)
                begin
                    tctl.look    = 1'b1;
                    tctl.addr    = cand_tok;
                    hit_tok_next = cand_tok;
                    hit_rec_next = cand_rec;
                    state_next   = S_TALLY;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end

            S_TALLY:
            begin
                tctl.upd   = 1'b1;
                state_next = S_STEP;
            end

            // Advance through the history or finish the pass
            S_STEP:
            begin
                if (!pass_b_reg && (idx_reg == count_reg - CNT_W'(1)))
                begin
                    if (tstat.any)
                    begin
                        pend_found_next = 1'b1;
                        pend_tok_next   = tstat.best;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pass_b_next = 1'b1;
                        idx_next    = CNT_W'(1);
                        state_next  = S_RING_RD;
                    end
                end
                else if (pass_b_reg && (idx_reg == count_reg))
                begin
                    pend_found_next = tstat.any;
                    pend_tok_next   = tstat.best;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_RING_RD;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_tok_next   = out_tok_reg;
        out_live_next  = out_live_reg;
        if ((state_reg == S_DONE) && slot_free)
        begin
            out_valid_next = 1'b1;
            out_found_next = pend_found_reg;
            out_tok_next   = pend_found_reg ? TOKEN_W'(pend_tok_reg) : '0;
            out_live_next  = LIVE_W'(count_reg);
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        clr_reg        <= clr_next;
        pass_b_reg     <= pass_b_next;
        newest_reg     <= newest_next;
        follow_reg     <= follow_next;
        hit_tok_reg    <= hit_tok_next;
        hit_rec_reg    <= hit_rec_next;
        pend_found_reg <= pend_found_next;
        pend_tok_reg   <= pend_tok_next;
        out_found_reg  <= out_found_next;
        out_tok_reg    <= out_tok_next;
        out_live_reg   <= out_live_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.found      = out_found_reg;
    assign res.token_out  = out_tok_reg;
    assign res.live_count = out_live_reg;

endmodule

/* hw/rtl/bntp_ring.sv */
// History ring memory: one write port and one registered read port.
// Depends on bntp_pkg for depth, widths and the control struct.
module bntp_ring (
    input  logic                            clk,
    input  bntp_pkg::ring_ctl_t             ctl,
    output logic [bntp_pkg::TOKEN_BITS-1:0] rd_data
);
    import bntp_pkg::*;

    logic [TOKEN_BITS-1:0] mem [0:HIST_DEPTH-1];
    logic [TOKEN_BITS-1:0] rd_data_reg;

    // Write one word
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/bntp_tally.sv */
// Tally table and the shared increment/compare unit that tracks the best token.
// Depends on bntp_pkg for widths, the control and status structs.
module bntp_tally (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bntp_pkg::tally_ctl_t  ctl,
    output bntp_pkg::tally_stat_t stat
);
    import bntp_pkg::*;

    tally_entry_t          mem [0:TOKEN_SPAN-1];
    tally_entry_t          rd_reg;
    tally_entry_t          upd_entry;
    logic                  better;
    logic                  any_reg;
    logic                  any_next;
    logic [TOKEN_BITS-1:0] best_reg;
    logic [TOKEN_BITS-1:0] best_next;
    logic [CNT_W-1:0]      best_cnt_reg;
    logic [CNT_W-1:0]      best_cnt_next;
    logic [CNT_W-1:0]      best_rec_reg;
    logic [CNT_W-1:0]      best_rec_next;

    // Build the updated entry from the word held in the read register
    always_comb
    begin
        upd_entry.cnt = rd_reg.cnt + CNT_W'(1);
        upd_entry.rec = (rd_reg.cnt == '0) ? ctl.rec : rd_reg.rec;
        better = !any_reg || (upd_entry.cnt > best_cnt_reg) ||
                 ((upd_entry.cnt == best_cnt_reg) && (upd_entry.rec > best_rec_reg));
    end

    // Write port: clear sweep or update
    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            mem[ctl.addr] <= '0;
        end
        else if (ctl.upd)
        begin
            mem[ctl.addr] <= upd_entry;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.look)
        begin
            rd_reg <= mem[ctl.addr];
        end
    end

    // Track the leading token as counts grow
    always_comb
    begin
        any_next      = any_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        best_rec_next = best_rec_reg;
        if (ctl.restart)
        begin
            any_next = 1'b0;
        end
        else if (ctl.upd && better)
        begin
            any_next      = 1'b1;
            best_next     = ctl.addr;
            best_cnt_next = upd_entry.cnt;
            best_rec_next = upd_entry.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
        best_rec_reg <= best_rec_next;
    end

    assign stat.any  = any_reg;
    assign stat.best = best_reg;

endmodule
